// ===== hdl/fdca_pkg.sv =====
package fdca_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int ADDR_W   = COL_W + ROW_W;
    localparam int WSIZE_W  = $clog2(MAX_WIDTH) + 1;
    localparam int HSIZE_W  = $clog2(MAX_HEIGHT) + 1;
    localparam int CFG_W    = 9;
    localparam int SAMPLE_W = 8;
    localparam int PIX_W    = 4 * SAMPLE_W;

    localparam logic [SAMPLE_W-1:0] ALPHA_OPAQUE = 8'd255;

    typedef logic [PIX_W-1:0] t_pixel;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        t_pixel            data;
    } t_canvas_wr;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_canvas_rd;

    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH       = 2'd0,
        CFG_FRAME_HEIGHT      = 2'd1,
        CFG_ALPHA_PRESENT     = 2'd2,
        CFG_CLEAN_TRANSPARENT = 2'd3
    } t_cfg_idx;

endpackage

// ===== hdl/fdca_canvas.sv =====
module fdca_canvas (
    input  logic                i_clk,
    input  fdca_pkg::t_canvas_rd i_rd,
    input  fdca_pkg::t_canvas_wr i_wr,
    output fdca_pkg::t_pixel    o_rd_data
);
    import fdca_pkg::*;

    t_pixel r_mem [2**ADDR_W];
    t_pixel r_rd_data;
    t_pixel r_fwd_data;
    logic   r_fwd_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // A read issued in the same cycle as a write to the same entry returns
    // the word being written.
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data  <= r_mem[i_rd.addr];
            r_fwd_hit  <= i_wr.en && (i_wr.addr == i_rd.addr);
            r_fwd_data <= i_wr.data;
        end
    end

    assign o_rd_data = r_fwd_hit ? r_fwd_data : r_rd_data;

endmodule

// ===== hdl/frame_delta_crop_analyzer_core.sv =====
// Result: the last pixel of a frame passes from the input-stage register into the output register,
// which it enters only when that register does not still hold an earlier stalled word.
// Throughput: one pixel word per cycle, set by the single canvas read-modify-write per pixel,
// with write-to-read forwarding between neighboring pixels. The input stalls only while the
// last pixel of a frame waits for a result word that is held by the output stall.
// Reset (synchronous, active low) clears the position counters, the change box and the
// output valid flag, and restores the configuration defaults; the canvas memory is not
// cleared, so the first frame after reset must be marked as the first of a sequence.
module frame_delta_crop_analyzer_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [1:0]                   i_cfg_index,
    input  logic [fdca_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [7:0]                   i_red,
    input  logic [7:0]                   i_green,
    input  logic [7:0]                   i_blue,
    input  logic [7:0]                   i_alpha,
    input  logic                         i_first_of_sequence,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [7:0]                   o_crop_x0,
    output logic [7:0]                   o_crop_y0,
    output logic [8:0]                   o_crop_width,
    output logic [8:0]                   o_crop_height,
    output logic                         o_is_cropped,
    output logic                         o_use_blend,
    output logic                         o_any_change
);
    import fdca_pkg::*;

    logic [WSIZE_W-1:0] r_width;
    logic [HSIZE_W-1:0] r_height;
    logic               r_alpha_en;
    logic               r_clean_en;

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;

    logic             r_s1_valid;
    t_pixel           r_s1_pix;
    logic [COL_W-1:0] r_s1_col;
    logic [ROW_W-1:0] r_s1_row;
    logic             r_s1_first;
    logic             r_s1_last;
    logic             r_s1_opaque;

    logic [COL_W-1:0] r_min_col, n_min_col;
    logic [COL_W-1:0] r_max_col, n_max_col;
    logic [ROW_W-1:0] r_min_row, n_min_row;
    logic [ROW_W-1:0] r_max_row, n_max_row;
    logic             r_diff_seen, n_diff_seen;
    logic             r_all_opaque, n_all_opaque;

    logic               r_out_valid;
    logic [COL_W-1:0]   r_out_x0;
    logic [ROW_W-1:0]   r_out_y0;
    logic [WSIZE_W-1:0] r_out_w;
    logic [HSIZE_W-1:0] r_out_h;
    logic               r_out_cropped;
    logic               r_out_blend;
    logic               r_out_change;

    logic               accept;
    logic               s1_go;
    logic               last_col;
    logic               last_pix;
    logic [WSIZE_W-1:0] col_inc;
    logic [HSIZE_W-1:0] row_inc;
    logic [SAMPLE_W-1:0] alpha_eff;
    logic               clean;
    t_pixel             pix;
    t_pixel             canvas_q;
    logic               diff;
    t_canvas_rd         canvas_rd;
    t_canvas_wr         canvas_wr;

    logic [COL_W-1:0]   res_x0;
    logic [ROW_W-1:0]   res_y0;
    logic [WSIZE_W-1:0] res_w;
    logic [HSIZE_W-1:0] res_h;
    logic               res_blend;
    logic               res_change;

    logic [CFG_W-1:0]   cfg_w_clamped;
    logic [CFG_W-1:0]   cfg_h_clamped;

    // Configuration port with size clamping.
    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_w_clamped = CFG_W'(1);
        end else if (i_cfg_data > CFG_W'(MAX_WIDTH)) begin
            cfg_w_clamped = CFG_W'(MAX_WIDTH);
        end else begin
            cfg_w_clamped = i_cfg_data;
        end
        if (i_cfg_data == '0) begin
            cfg_h_clamped = CFG_W'(1);
        end else if (i_cfg_data > CFG_W'(MAX_HEIGHT)) begin
            cfg_h_clamped = CFG_W'(MAX_HEIGHT);
        end else begin
            cfg_h_clamped = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= WSIZE_W'(MAX_WIDTH);
            r_height   <= HSIZE_W'(MAX_HEIGHT);
            r_alpha_en <= 1'b1;
            r_clean_en <= 1'b1;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FRAME_WIDTH:       r_width    <= WSIZE_W'(cfg_w_clamped);
                CFG_FRAME_HEIGHT:      r_height   <= HSIZE_W'(cfg_h_clamped);
                CFG_ALPHA_PRESENT:     r_alpha_en <= i_cfg_data[0];
                CFG_CLEAN_TRANSPARENT: r_clean_en <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Input side: pixel cleaning, position tracking and canvas read.
    assign s1_go      = r_s1_valid && (!r_s1_last || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_go;
    assign accept     = i_in_valid && !o_in_stall;

    assign alpha_eff = r_alpha_en ? i_alpha : ALPHA_OPAQUE;
    assign clean     = r_alpha_en && r_clean_en && (alpha_eff == '0);
    assign pix       = clean ? {alpha_eff, {(3 * SAMPLE_W){1'b0}}}
                             : {alpha_eff, i_blue, i_green, i_red};

    assign col_inc  = {1'b0, r_col} + WSIZE_W'(1);
    assign row_inc  = {1'b0, r_row} + HSIZE_W'(1);
    assign last_col = col_inc >= r_width;
    assign last_pix = last_col && (row_inc >= r_height);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (last_pix) begin
                n_col = '0;
                n_row = '0;
            end else if (last_col) begin
                n_col = '0;
                n_row = row_inc[ROW_W-1:0];
            end else begin
                n_col = col_inc[COL_W-1:0];
            end
        end
    end

    assign canvas_rd.en   = accept;
    assign canvas_rd.addr = {r_row, r_col};
    assign canvas_wr.en   = s1_go;
    assign canvas_wr.addr = {r_s1_row, r_s1_col};
    assign canvas_wr.data = r_s1_pix;

    fdca_canvas u_canvas (
        .i_clk     (i_clk),
        .i_rd      (canvas_rd),
        .i_wr      (canvas_wr),
        .o_rd_data (canvas_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix    <= pix;
            r_s1_col    <= r_col;
            r_s1_row    <= r_row;
            r_s1_first  <= i_first_of_sequence;
            r_s1_last   <= last_pix;
            r_s1_opaque <= alpha_eff == ALPHA_OPAQUE;
        end
    end

    // Compare stage: box update and frame result.
    assign diff = !r_s1_first && (canvas_q != r_s1_pix);

    always_comb begin
        n_min_col    = r_min_col;
        n_max_col    = r_max_col;
        n_min_row    = r_min_row;
        n_max_row    = r_max_row;
        n_diff_seen  = r_diff_seen;
        n_all_opaque = r_all_opaque;
        if (diff) begin
            if (!r_diff_seen) begin
                n_min_col = r_s1_col;
                n_max_col = r_s1_col;
                n_min_row = r_s1_row;
                n_max_row = r_s1_row;
            end else begin
                if (r_s1_col < r_min_col) n_min_col = r_s1_col;
                if (r_s1_col > r_max_col) n_max_col = r_s1_col;
                if (r_s1_row < r_min_row) n_min_row = r_s1_row;
                if (r_s1_row > r_max_row) n_max_row = r_s1_row;
            end
            n_diff_seen  = 1'b1;
            n_all_opaque = r_all_opaque && r_s1_opaque;
        end
    end

    always_comb begin
        if (r_s1_first) begin
            res_x0     = '0;
            res_y0     = '0;
            res_w      = r_width;
            res_h      = r_height;
            res_blend  = 1'b0;
            res_change = 1'b0;
        end else if (n_diff_seen) begin
            res_x0     = n_min_col;
            res_y0     = n_min_row;
            res_w      = {1'b0, n_max_col} - {1'b0, n_min_col} + WSIZE_W'(1);
            res_h      = {1'b0, n_max_row} - {1'b0, n_min_row} + HSIZE_W'(1);
            res_blend  = r_alpha_en && n_all_opaque;
            res_change = 1'b1;
        end else begin
            res_x0     = '0;
            res_y0     = '0;
            res_w      = WSIZE_W'(1);
            res_h      = HSIZE_W'(1);
            res_blend  = r_alpha_en;
            res_change = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_col    <= '1;
            r_max_col    <= '0;
            r_min_row    <= '1;
            r_max_row    <= '0;
            r_diff_seen  <= 1'b0;
            r_all_opaque <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            if (s1_go) begin
                if (r_s1_last) begin
                    r_min_col    <= '1;
                    r_max_col    <= '0;
                    r_min_row    <= '1;
                    r_max_row    <= '0;
                    r_diff_seen  <= 1'b0;
                    r_all_opaque <= 1'b1;
                end else begin
                    r_min_col    <= n_min_col;
                    r_max_col    <= n_max_col;
                    r_min_row    <= n_min_row;
                    r_max_row    <= n_max_row;
                    r_diff_seen  <= n_diff_seen;
                    r_all_opaque <= n_all_opaque;
                end
            end
            if (s1_go && r_s1_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_last) begin
            r_out_x0      <= res_x0;
            r_out_y0      <= res_y0;
            r_out_w       <= res_w;
            r_out_h       <= res_h;
            r_out_cropped <= (res_x0 != '0) || (res_y0 != '0)
                             || (res_w != r_width) || (res_h != r_height);
            r_out_blend   <= res_blend;
            r_out_change  <= res_change;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_crop_x0     = r_out_x0;
    assign o_crop_y0     = r_out_y0;
    assign o_crop_width  = r_out_w;
    assign o_crop_height = r_out_h;
    assign o_is_cropped  = r_out_cropped;
    assign o_use_blend   = r_out_blend;
    assign o_any_change  = r_out_change;

    a_box_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_diff_seen |-> (r_min_col <= r_max_col) && (r_min_row <= r_max_row))
        else $error("change box corners out of order");

    a_box_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && r_s1_last) |=> !r_diff_seen && r_all_opaque)
        else $error("change box not cleared after frame end");

    a_result_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_crop_width != '0) && (o_crop_height != '0))
        else $error("empty crop rectangle reported");

endmodule
